[sv/tnl_pkg.sv]
// package with widths, codes, state and command types of the trapezoid log block
`default_nettype none
package tnl_pkg;

  localparam int unsigned MAX_INTERVALS = 4096;

  localparam int unsigned ARG_W  = 24;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned LOG_W  = 32;
  localparam int unsigned STAT_W = 2;

  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 40;

  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned H_W    = ARG_W + FRAC_SHIFT;
  localparam int unsigned T_W    = H_W + 1;
  localparam int unsigned REC_W  = 33;
  localparam int unsigned NODE_W = $clog2(MAX_INTERVALS + 1);
  localparam int unsigned SUM_W  = REC_W + NODE_W;
  localparam int unsigned PROD_W = SUM_W + H_W;
  localparam int unsigned RES_SHIFT = 41;
  localparam int unsigned STEP_W = 6;

  localparam logic [ARG_W-1:0] ONE_Q16 = ARG_W'(32'h0001_0000);

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BELOW    = 2'd1,
    ST_ZERO_CNT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_H,
    S_INIT,
    S_REC_START,
    S_REC,
    S_ACCUM,
    S_MUL_START,
    S_MUL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic h_start;
    logic div_step;
    logic node_init;
    logic rec_start;
    logic accum;
    logic mul_start;
    logic mul_step;
    logic out_write;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic last_node;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

[sv/tnl_ctrl.sv]
// sequencer for the trapezoid log block: steps through division, node loop and multiply
`default_nettype none
module tnl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire tnl_pkg::stat_t stat_i,
  output tnl_pkg::cmd_t      cmd_o
);
  import tnl_pkg::*;

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic step_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    case (state_q)
      S_DIV_H, S_MUL: step_last = (step_q == STEP_W'(H_W - 1));
      S_REC:          step_last = (step_q == STEP_W'(REC_W - 1));
      default:        step_last = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        step_d  = '0;
        state_d = stat_i.err ? S_DONE : S_DIV_H;
      end
      S_DIV_H: begin
        step_d = step_q + 1'b1;
        if (step_last) state_d = S_INIT;
      end
      S_INIT: begin
        state_d = S_REC_START;
      end
      S_REC_START: begin
        step_d  = '0;
        state_d = S_REC;
      end
      S_REC: begin
        step_d = step_q + 1'b1;
        if (step_last) state_d = S_ACCUM;
      end
      S_ACCUM: begin
        state_d = stat_i.last_node ? S_MUL_START : S_REC_START;
      end
      S_MUL_START: begin
        step_d  = '0;
        state_d = S_MUL;
      end
      S_MUL: begin
        step_d = step_q + 1'b1;
        if (step_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!stat_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // input stays closed while reset is held
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = rst_ni;
        cmd_o.load  = in_valid_i && rst_ni;
      end
      S_CHECK:     cmd_o.h_start   = 1'b1;
      S_DIV_H:     cmd_o.div_step  = 1'b1;
      S_INIT:      cmd_o.node_init = 1'b1;
      S_REC_START: cmd_o.rec_start = 1'b1;
      S_REC:       cmd_o.div_step  = 1'b1;
      S_ACCUM:     cmd_o.accum     = 1'b1;
      S_MUL_START: cmd_o.mul_start = 1'b1;
      S_MUL:       cmd_o.mul_step  = 1'b1;
      S_DONE:      cmd_o.out_write = !stat_i.out_busy;
      default:     cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

[sv/tnl_datapath.sv]
// datapath: input check, shared restoring divider, reciprocal sum, serial multiply, output word
`default_nettype none
module tnl_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire tnl_pkg::cmd_t               cmd_i,
  output tnl_pkg::stat_t                   stat_o,
  input  wire logic [tnl_pkg::ARG_W-1:0]   argument_i,
  input  wire logic [tnl_pkg::CNT_W-1:0]   interval_count_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [tnl_pkg::LOG_W-1:0]        log_value_o,
  output logic [tnl_pkg::STAT_W-1:0]       status_o
);
  import tnl_pkg::*;

  logic [ARG_W-1:0]  arg_q;
  logic [NODE_W-1:0] n_q, n_d;
  status_e           status_q, status_d;
  logic [H_W-1:0]    h_q;
  logic [T_W-1:0]    div_q;
  logic [T_W-1:0]    rem_q;
  logic [H_W-1:0]    quo_q;
  logic [NODE_W-1:0] node_q;
  logic [REC_W-1:0]  prev_q;
  logic [SUM_W-1:0]  sum_q;
  logic [PROD_W-1:0] prod_q;
  logic              out_valid_q;
  logic [LOG_W-1:0]  log_q;
  logic [STAT_W-1:0] stat_q;

  logic [T_W:0]        rem_shift;
  logic                rem_ge;
  logic [T_W:0]        rem_sub;
  logic [REC_W-1:0]    rec_cur;
  logic [SUM_W-PROD_W+PROD_W:0] mul_upper;
  logic [LOG_W-1:0]    log_res;
  logic [T_W-1:0]      t_next;

  // input check and interval clamp
  always_comb begin
    if (argument_i < ONE_Q16) status_d = ST_BELOW;
    else if (interval_count_i == '0) status_d = ST_ZERO_CNT;
    else status_d = ST_OK;
    if (32'(interval_count_i) > 32'(MAX_INTERVALS)) n_d = NODE_W'(MAX_INTERVALS);
    else n_d = NODE_W'(interval_count_i);
  end

  // one restoring division step, shared by the step and the reciprocals
  assign rem_shift = {rem_q, quo_q[H_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, div_q};
  assign rem_sub   = rem_shift - {1'b0, div_q};
  assign rec_cur   = quo_q[REC_W-1:0];
  assign t_next    = div_q + T_W'(h_q);

  // shift-add multiply, high part plus the sum
  assign mul_upper = (SUM_W + 1)'(prod_q[PROD_W-1:H_W])
                   + (SUM_W + 1)'(prod_q[0] ? sum_q : '0);

  always_comb begin
    if (prod_q[PROD_W-1:RES_SHIFT+LOG_W] != '0) log_res = '1;
    else log_res = prod_q[RES_SHIFT+LOG_W-1:RES_SHIFT];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arg_q    <= argument_i;
      n_q      <= n_d;
      status_q <= status_d;
    end
    if (cmd_i.h_start) begin
      rem_q <= '0;
      quo_q <= {arg_q - ONE_Q16, FRAC_SHIFT'(0)};
      div_q <= T_W'(n_q);
    end
    if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_sub[T_W-1:0];
        quo_q <= {quo_q[H_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_shift[T_W-1:0];
        quo_q <= {quo_q[H_W-2:0], 1'b0};
      end
    end
    if (cmd_i.node_init) begin
      h_q    <= quo_q;
      div_q  <= T_W'(64'h1_0000_0000);
      prev_q <= REC_W'(64'h1_0000_0000);
      sum_q  <= '0;
      node_q <= NODE_W'(1);
    end
    if (cmd_i.rec_start) begin
      // t_i = t_(i-1) + h, dividend 2^64 starts with 2^31 left over
      div_q <= t_next;
      rem_q <= T_W'(64'h8000_0000);
      quo_q <= '0;
    end
    if (cmd_i.accum) begin
      sum_q  <= sum_q + SUM_W'(prev_q) + SUM_W'(rec_cur);
      prev_q <= rec_cur;
      if (node_q != n_q) node_q <= node_q + 1'b1;
    end
    if (cmd_i.mul_start) begin
      prod_q <= PROD_W'(h_q);
    end
    if (cmd_i.mul_step) begin
      prod_q <= {mul_upper[SUM_W:0], prod_q[H_W-1:1]};
    end
    if (cmd_i.out_write) begin
      stat_q <= status_q;
      log_q  <= (status_q == ST_OK) ? log_res : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.err       = (status_q != ST_OK);
  assign stat_o.last_node = (node_q == n_q);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign log_value_o = log_q;
  assign status_o    = stat_q;

endmodule
`default_nettype wire

[sv/trapezoid_natural_log.sv]
// top level of the trapezoidal-rule natural logarithm block
`default_nettype none
// usage
// - input stream s_axis: one word carries argument x (unsigned q8.16) and the
//   interval count n; a word is taken when tvalid and tready are both high
// - output stream m_axis: one word per input word with ln(x) in unsigned q8.24
//   (saturated) and a status code; zero value on any error status
// - one word is worked on at a time; s_axis_tready is high only while the
//   sequencer is idle and reset is released
// - a rejected word (x below one or n of zero) goes from the check state straight
//   to the done state, where its result is registered
// - an accepted word, n clamped to 4096, passes the check, the step division,
//   the node setup, then per node a reciprocal division on the shared restoring
//   divider plus setup and accumulate, then the shift-add multiply; its result
//   is registered in the done state, after which the sequencer goes idle
// - the result sits in an output register; while the receiver stalls it holds
//   there and the sequencer waits in its last state before going idle, so a
//   new word can be taken as soon as the finished one is registered
// - reset clears the sequencer and the output valid flag, so a word in progress
//   or an unread result is dropped and none is invented; the arithmetic registers need no reset
module trapezoid_natural_log (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // argument [23:0], interval_count [36:24], zero pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // log_value [31:0], status [33:32], zero pad
);
  import tnl_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic [LOG_W-1:0]  log_value;
  logic [STAT_W-1:0] status;

  // sequencer
  tnl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // arithmetic and output register
  tnl_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .argument_i       (s_axis_tdata[ARG_W-1:0]),
    .interval_count_i (s_axis_tdata[ARG_W+CNT_W-1:ARG_W]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .log_value_o      (log_value),
    .status_o         (status)
  );

  // pack result word, lowest field first
  assign m_axis_tdata = {(OUT_W - LOG_W - STAT_W)'(0), status, log_value};

  // a taken word closes the input until the sequencer is idle again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // error results carry a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[33:32] != 2'd0) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("error result with nonzero value");

  // status code three is never produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[33:32] != 2'd3))
    else $error("undefined status code");

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule
`default_nettype wire
